[rtl/dzv_pkg.sv]
// ----------------------------------------------------------------------------
// dzv_pkg
// Shared types and constants for the delta / zigzag varint encoder.
// ----------------------------------------------------------------------------
package dzv_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned VarBitsW = 7;
  localparam int unsigned RawBytes = 8;
  localparam int unsigned MaxBytes = 10;
  localparam int unsigned CntW     = 4;
  localparam int unsigned SignBit  = 63;
  localparam logic [ByteW-1:0] ContBit = 8'h80;

  // How the back end serializes one queued word
  typedef enum logic {
    KIND_RAW,
    KIND_VARINT
  } kind_e;

  // One classified item between front and back end
  typedef struct packed {
    kind_e             kind;
    logic [DataW-1:0]  value;  // raw sample, or first difference
    logic [DataW-1:0]  base;   // subtracted from value for varint words
  } entry_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/delta_zigzag_varint_encoder.sv]
// ----------------------------------------------------------------------------
// delta_zigzag_varint_encoder
// Encodes 64-bit samples as raw headers followed by zigzag varint deltas or
// delta-of-deltas, one output byte per accepted pop.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// input     in         push / full       sample_i, sequence_start_i
// result    out        pop / empty       out_byte_o, run_last_o
// config    in         cfg_we_i          cfg_wdata_i (order_mode)
//
// Each sample yields 8 bytes (raw) or 1 to 10 bytes (varint); the byte
// serializer emits one byte per cycle while pop is held high.
// The front end writes each sample into a QUEUE_DEPTH-entry queue, so it keeps
// accepting while the serializer drains or the output stalls, until the queue is full.
// Reset clears sequence state, the mode register and the queue.
// ----------------------------------------------------------------------------
module delta_zigzag_varint_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic signed [63:0]  sample_i,
  input  logic                sequence_start_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o
);
  import dzv_pkg::*;

  entry_t     fe_entry;
  entry_t     q_entry;
  fifo_stat_t q_stat;
  logic       accept;
  logic       q_rd;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  // Front end: classify and track sequence state
  dzv_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .sample_i         (sample_i),
    .sequence_start_i (sequence_start_i),
    .entry_o          (fe_entry)
  );

  // Decoupling queue
  dzv_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (fe_entry),
    .rd_i    (q_rd),
    .rdata_o (q_entry),
    .stat_o  (q_stat)
  );

  // Back end: byte serializer
  dzv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (q_entry),
    .have_entry_i (!q_stat.empty),
    .rd_o         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o)
  );

endmodule

[rtl/dzv_front.sv]
// ----------------------------------------------------------------------------
// dzv_front
// Accepts samples, tracks sequence state and classifies each word as raw or
// varint, producing the queue entry.
// ----------------------------------------------------------------------------
module dzv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                accept_i,
  input  logic signed [63:0]  sample_i,
  input  logic                sequence_start_i,
  output dzv_pkg::entry_t     entry_o
);
  import dzv_pkg::*;

  logic             order_mode_q, order_mode_d;
  logic [DataW-1:0] prev_sample_q, prev_sample_d;
  logic [DataW-1:0] prev_delta_q, prev_delta_d;
  logic [1:0]       items_seen_q, items_seen_d;

  logic             first;
  logic             use_raw;
  logic [DataW-1:0] sample_u;
  logic [DataW-1:0] delta;

  // Classification and first difference
  always_comb begin
    sample_u = $unsigned(sample_i);
    first    = sequence_start_i || (items_seen_q == 2'd0);
    delta    = sample_u - prev_sample_q;
    use_raw  = first || (order_mode_q && (items_seen_q == 2'd1));

    entry_o.kind  = use_raw ? KIND_RAW : KIND_VARINT;
    entry_o.value = use_raw ? sample_u : delta;
    entry_o.base  = (!first && order_mode_q && (items_seen_q == 2'd2)) ?
                    prev_delta_q : '0;
  end

  // Sequence state update
  always_comb begin
    order_mode_d  = cfg_we_i ? cfg_wdata_i : order_mode_q;
    prev_sample_d = prev_sample_q;
    prev_delta_d  = prev_delta_q;
    items_seen_d  = items_seen_q;
    if (accept_i) begin
      prev_sample_d = sample_u;
      prev_delta_d  = first ? '0 : delta;
      if (first) begin
        items_seen_d = 2'd1;
      end else if (items_seen_q != 2'd2) begin
        items_seen_d = items_seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q  <= 1'b0;
      prev_sample_q <= '0;
      prev_delta_q  <= '0;
      items_seen_q  <= 2'd0;
    end else begin
      order_mode_q  <= order_mode_d;
      prev_sample_q <= prev_sample_d;
      prev_delta_q  <= prev_delta_d;
      items_seen_q  <= items_seen_d;
    end
  end

`ifndef SYNTH
  // A sequence start always leaves exactly one sample seen
  a_start_sets_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && sequence_start_i) |=> (items_seen_q == 2'd1))
    else $error("items_seen not one after sequence start");
`endif

endmodule

[rtl/dzv_fifo.sv]
// ----------------------------------------------------------------------------
// dzv_fifo
// Short register queue of classified entries between front and back end.
// ----------------------------------------------------------------------------
module dzv_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  dzv_pkg::entry_t      wdata_i,
  input  logic                 rd_i,
  output dzv_pkg::entry_t      rdata_o,
  output dzv_pkg::fifo_stat_t  stat_o
);
  import dzv_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntQW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntQW-1:0] FullCnt = CntQW'(DEPTH);

  entry_t           mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTH
  // Back end never reads an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> (count_q != '0))
    else $error("queue read while empty");
`endif

endmodule

[rtl/dzv_back.sv]
// ----------------------------------------------------------------------------
// dzv_back
// Serializes queued entries into bytes: eight raw bytes, or a zigzag varint
// of one to ten bytes, one byte per accepted pop.
// ----------------------------------------------------------------------------
module dzv_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dzv_pkg::entry_t  entry_i,
  input  logic             have_entry_i,
  output logic             rd_o,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o
);
  import dzv_pkg::*;

  logic             busy_q, busy_d;
  kind_e            kind_q, kind_d;
  logic [DataW-1:0] sh_q, sh_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             byte_last;
  logic [DataW-1:0] diff;
  logic [DataW-1:0] zz;

  // Current byte from the shift register
  always_comb begin
    if (kind_q == KIND_RAW) begin
      byte_last  = (cnt_q == CntW'(RawBytes - 1));
      out_byte_o = sh_q[ByteW-1:0];
    end else begin
      byte_last  = (sh_q[DataW-1:VarBitsW] == '0);
      out_byte_o = {1'b0, sh_q[VarBitsW-1:0]} | (byte_last ? '0 : ContBit);
    end
  end

  assign run_last_o = byte_last;
  assign empty      = !busy_q;

  // Take the next entry when idle or when the last byte leaves
  assign rd_o = have_entry_i && (!busy_q || (pop && byte_last));

  // Value minus base (delta of deltas, or the plain delta when base is zero) and zigzag map
  always_comb begin
    diff = entry_i.value - entry_i.base;
    zz   = {diff[DataW-2:0], 1'b0} ^ {DataW{diff[SignBit]}};
  end

  always_comb begin
    busy_d = busy_q;
    kind_d = kind_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    if (rd_o) begin
      busy_d = 1'b1;
      kind_d = entry_i.kind;
      sh_d   = (entry_i.kind == KIND_RAW) ? entry_i.value : zz;
      cnt_d  = '0;
    end else if (pop && busy_q) begin
      if (byte_last) begin
        busy_d = 1'b0;
      end else begin
        sh_d  = (kind_q == KIND_RAW) ? (sh_q >> ByteW) : (sh_q >> VarBitsW);
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= KIND_RAW;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

`ifndef SYNTH
  // No word ever runs past ten bytes
  a_max_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q < CntW'(MaxBytes)))
    else $error("byte count past limit");

  // Popping a non-final byte keeps the word in progress
  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pop && !byte_last) |=> (busy_q && (cnt_q == $past(cnt_q) + 1'b1)))
    else $error("word dropped before last byte");
`endif

endmodule
